// File: hdl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// Levenshtein row step package
// Shared constants, register indexes, saturating helper and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

  // Default number of target bytes the row can hold.
  localparam int unsigned MaxTargetDef = 16;

  // Target bytes carried by the configuration registers.
  localparam int unsigned RegBytes = 16;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_TARGET_LEN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHARS_LO   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CHARS_HI   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_DIST   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take a new input word
    logic step;    // update the current cell
    logic emit;    // load the result into the output register
  } lrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;  // the current cell is the last live one
    logic out_free;   // the output register can take a result this cycle
  } lrs_sts_t;

  // Add d to v and saturate at 255.
  function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic d);
    logic [8:0] s;
    s = {1'b0, v} + {8'd0, d};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/lrs_ctrl.sv
// ----------------------------------------------------------------------------
// Levenshtein row step controller
// Sequences one character: accept, one cell update per cycle, then a hand-off
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_ctrl
  import lrs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lrs_sts_t sts_i,
  output lrs_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } lrs_state_e;

  lrs_state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_cell) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lrs_datapath.sv
// ----------------------------------------------------------------------------
// Levenshtein row step datapath
// Holds the configuration, the DP row and one shared cell update unit that
// walks the row one cell per cycle, plus the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_datapath
  import lrs_pkg::*;
#(
  parameter int unsigned MAX_TARGET = MaxTargetDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [7:0]          ch_i,
  input  wire logic                start_req_i,
  input  wire lrs_cmd_t            cmd_i,
  output lrs_sts_t                 sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               dist_res_o,
  output logic                     accept_o,
  output logic                     alive_o
);

  localparam int unsigned IdxW  = $clog2(MAX_TARGET + 1);
  localparam int unsigned ByteW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned LenW  = (IdxW > 5) ? IdxW : 5;

  // Configuration registers.
  logic [4:0]  target_len_q;
  logic [63:0] chars_lo_q;
  logic [63:0] chars_hi_q;
  logic [7:0]  max_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_len_q <= '0;
      chars_lo_q   <= '0;
      chars_hi_q   <= '0;
      max_dist_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_LEN: target_len_q <= cfg_wdata_i[4:0];
        REG_CHARS_LO:   chars_lo_q   <= cfg_wdata_i;
        REG_CHARS_HI:   chars_hi_q   <= cfg_wdata_i;
        REG_MAX_DIST:   max_dist_q   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Target bytes; bytes beyond the registers read as zero.
  logic [7:0] tgt_bytes [MAX_TARGET];

  for (genvar gi = 0; gi < MAX_TARGET; gi++) begin : g_tgt
    if (gi < 8) begin : g_lo
      assign tgt_bytes[gi] = chars_lo_q[8*gi +: 8];
    end else if (gi < RegBytes) begin : g_hi
      assign tgt_bytes[gi] = chars_hi_q[8*(gi-8) +: 8];
    end else begin : g_zero
      assign tgt_bytes[gi] = 8'h00;
    end
  end

  // Live length, clamped to the row size.
  logic [LenW-1:0] len_ext;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    len_ext = LenW'(target_len_q);
    if (len_ext > LenW'(MAX_TARGET)) begin
      last_idx = IdxW'(MAX_TARGET);
    end else begin
      last_idx = len_ext[IdxW-1:0];
    end
  end

  // Walk state: current cell, old and new values of the previous cell,
  // running minimum of the new row and the character in flight.
  logic [IdxW-1:0] idx_q;
  logic [7:0]      old_prev_q;
  logic [7:0]      new_prev_q;
  logic [7:0]      low_q;
  logic [7:0]      ch_q;
  logic [7:0]      row_q [MAX_TARGET+1];

  // Shared cell update unit.
  logic [ByteW-1:0] byte_idx;
  logic [7:0]       old_cell;
  logic             cost;
  logic [7:0]       sub_c;
  logic [7:0]       ins_c;
  logic [7:0]       del_c;
  logic [7:0]       new_cell;
  logic [7:0]       low_d;

  always_comb begin
    byte_idx = ByteW'(idx_q - IdxW'(1));
    old_cell = row_q[idx_q];
    cost     = (tgt_bytes[byte_idx] != ch_q);
    sub_c    = sat_inc(old_prev_q, cost);
    ins_c    = sat_inc(new_prev_q, 1'b1);
    del_c    = sat_inc(old_cell, 1'b1);
    if (idx_q == '0) begin
      new_cell = del_c;
      low_d    = del_c;
    end else begin
      new_cell = sub_c;
      if (ins_c < new_cell) begin
        new_cell = ins_c;
      end
      if (del_c < new_cell) begin
        new_cell = del_c;
      end
      low_d = (new_cell < low_q) ? new_cell : low_q;
    end
  end

  // The row: reloaded as a whole on a start, one cell written per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= MAX_TARGET; j++) begin
        row_q[j] <= 8'(j);
      end
    end else if (cmd_i.accept && start_req_i) begin
      for (int j = 0; j <= MAX_TARGET; j++) begin
        row_q[j] <= 8'(j);
      end
    end else if (cmd_i.step) begin
      row_q[idx_q] <= new_cell;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= ch_i;
    end
    if (cmd_i.step) begin
      old_prev_q <= old_cell;
      new_prev_q <= new_cell;
      low_q      <= low_d;
    end
  end

  // Output register: takes a result while empty or while its word leaves.
  logic out_valid_q;
  logic [7:0] dist_q;
  logic accept_q;
  logic alive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dist_q   <= new_prev_q;
      accept_q <= (new_prev_q <= max_dist_q);
      alive_q  <= (low_q <= max_dist_q);
    end
  end

  assign sts_o.last_cell = (idx_q == last_idx);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign dist_res_o  = dist_q;
  assign accept_o    = accept_q;
  assign alive_o     = alive_q;

endmodule

`default_nettype wire

// File: hdl/levenshtein_row_step_core.sv
// ----------------------------------------------------------------------------
// Levenshtein row step core
// One row of the Levenshtein edit-distance table, advanced by one character
// per input word, with distance and match flags per step.
// ----------------------------------------------------------------------------
// Each input word is first accepted, then the single shared cell update unit
// walks cells 0 to m in order, where m is target_len clamped to MAX_TARGET
// (each cell needs the new value of the one before it), and the result is
// then loaded into the output register. The next word is accepted while a
// finished result still waits in the output register; the walk only pauses
// at its end when that register is still occupied. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_wdata_i while the core is idle; the
// user must keep to this, as the core itself does not enforce it.
`default_nettype none

module levenshtein_row_step_core
  import lrs_pkg::*;
#(
  parameter int unsigned MAX_TARGET = MaxTargetDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          ch_i,
  input  wire logic                start_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               dist_res_o,
  output logic                     accept_o,
  output logic                     alive_o
);

  lrs_cmd_t cmd;
  lrs_sts_t sts;

  lrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrs_datapath #(
    .MAX_TARGET (MAX_TARGET)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dist_res_o  (dist_res_o),
    .accept_o    (accept_o),
    .alive_o     (alive_o)
  );

  // At most one command is active in any cycle.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.step, cmd.emit}))
    else $error("more than one controller command active");

  // No cell is updated while the input side is open.
  a_no_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.step)
    else $error("cell update while accepting a new word");

  // A loaded result is presented in the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("result loaded but output word not valid");

  // A result is only loaded when the output register has room.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a waiting output word");

endmodule

`default_nettype wire

// File: verif/tb_levenshtein_row_step_core.sv
// ----------------------------------------------------------------------------
// Levenshtein row step core testbench
// Streams characters into the core under several target words, lengths and
// distance limits, predicts every result word with a local copy of the edit
// distance row, and checks the results in order under random idling.
// ----------------------------------------------------------------------------

module tb_levenshtein_row_step_core;
  import lrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned PhaseChars = 150;
  localparam int unsigned SatChars   = 320;
  localparam int unsigned NumPhases  = 12;

  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
  } char_item_t;

  typedef struct packed {
    logic [7:0] dist_val;
    logic       hit;
    logic       live;
  } row_result_t;

  // Block ports.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          ch_i        = 8'd0;
  logic                start_req_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          dist_res_o;
  logic                accept_o;
  logic                alive_o;

  // Local copy of the register file and of the distance row.
  logic [4:0]  len_reg  = '0;
  logic [63:0] lo_reg   = '0;
  logic [63:0] hi_reg   = '0;
  logic [7:0]  max_reg  = '0;
  logic [7:0]  row_cells [0:MaxTargetDef];

  char_item_t  char_q[$];
  row_result_t score_q[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left;
  int unsigned cycle_cnt     = 0;
  int unsigned mismatches    = 0;
  int unsigned chars_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned sat_seen      = 0;
  int unsigned hit_seen      = 0;
  int unsigned settings_cnt  = 0;

  levenshtein_row_step_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dist_res_o  (dist_res_o),
    .accept_o    (accept_o),
    .alive_o     (alive_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run length guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] add_sat(logic [7:0] v, logic d);
    logic [8:0] s;
    s = {1'b0, v} + {8'd0, d};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Advance the local row by one character and return the flags it gives.
  function automatic row_result_t advance_row(logic [7:0] c, logic restart);
    logic [7:0]   nxt [0:MaxTargetDef];
    logic [127:0] word;
    logic [7:0]   best;
    logic [7:0]   cand;
    logic [7:0]   lowest;
    int           m;
    row_result_t  r;
    m    = (len_reg > MaxTargetDef) ? int'(MaxTargetDef) : int'(len_reg);
    word = {hi_reg, lo_reg};
    if (restart) begin
      for (int j = 0; j <= MaxTargetDef; j++) row_cells[j] = 8'(j);
    end
    nxt[0] = add_sat(row_cells[0], 1'b1);
    for (int j = 1; j <= m; j++) begin
      best = add_sat(row_cells[j-1], word[8*(j-1) +: 8] != c);
      cand = add_sat(nxt[j-1], 1'b1);
      if (cand < best) best = cand;
      cand = add_sat(row_cells[j], 1'b1);
      if (cand < best) best = cand;
      nxt[j] = best;
    end
    lowest = nxt[0];
    for (int j = 0; j <= m; j++) begin
      row_cells[j] = nxt[j];
      if (nxt[j] < lowest) lowest = nxt[j];
    end
    r.dist_val = nxt[m];
    r.hit      = nxt[m] <= max_reg;
    r.live     = lowest <= max_reg;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // Sender: the word on the bus stays put until the core takes it, and each
  // taken word is run through the local row at once.
  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t item;
    bit         busy;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      ch_i        <= 8'd0;
      start_req_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        score_q = {score_q, advance_row(ch_i, start_req_i)};
        chars_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = char_q.pop_front();
          in_valid_i  <= 1'b1;
          ch_i        <= item.ch;
          start_req_i <= item.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the core backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end
  end

  // Receiver: compare each taken result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (score_q.size() == 0) begin
          report_mismatch($sformatf("result word dist_res=%0d with nothing expected",
                                    dist_res_o));
        end else begin
          want = score_q.pop_front();
          if (dist_res_o !== want.dist_val)
            report_mismatch($sformatf("dist_res %0d, expected %0d", dist_res_o,
                                      want.dist_val));
          if (accept_o !== want.hit)
            report_mismatch($sformatf("accept %0b, expected %0b", accept_o, want.hit));
          if (alive_o !== want.live)
            report_mismatch($sformatf("alive %0b, expected %0b", alive_o, want.live));
          if (want.dist_val == 8'hFF) sat_seen++;
          if (want.hit) hit_seen++;
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic add_char(logic [7:0] c, logic restart);
    char_item_t item;
    item.ch      = c;
    item.restart = restart;
    char_q = {char_q, item};
  endtask

  // Wait until every queued word went through and its result came back,
  // then give the core time to finish its walk.
  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid_i || score_q.size() != 0) @(negedge clk_i);
    repeat (MaxTargetDef + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_TARGET_LEN: len_reg = val[4:0];
      REG_CHARS_LO:   lo_reg  = val;
      REG_CHARS_HI:   hi_reg  = val;
      REG_MAX_DIST:   max_reg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic setup_regs(logic [4:0] len, logic [63:0] lo, logic [63:0] hi,
                            logic [7:0] maxd);
    wait_drained();
    write_reg(REG_TARGET_LEN, {59'd0, len});
    write_reg(REG_CHARS_LO, lo);
    write_reg(REG_CHARS_HI, hi);
    write_reg(REG_MAX_DIST, {56'd0, maxd});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  // Queue a copy of the target with random edits, starting a new word.
  task automatic push_word();
    logic [127:0] word;
    logic [7:0]   c;
    int           m;
    int           roll;
    int           before_cnt;
    bit           first;
    m          = (len_reg > MaxTargetDef) ? int'(MaxTargetDef) : int'(len_reg);
    word       = {hi_reg, lo_reg};
    first      = 1'b1;
    before_cnt = char_q.size();
    for (int j = 0; j <= m; j++) begin
      roll = $urandom_range(99);
      c    = (j < m) ? word[8*j +: 8] : 8'($urandom);
      if (j == m && roll < 70) continue;
      if (roll < 8) continue;
      if (roll < 16) begin
        c = 8'($urandom);
      end else if (roll < 22) begin
        add_char(8'($urandom), first);
        first = 1'b0;
      end
      add_char(c, first);
      first = 1'b0;
    end
    if (char_q.size() == before_cnt) add_char(8'($urandom), 1'b1);
  endtask

  // Stimulus.
  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [7:0]  maxd;
    int unsigned queued;

    for (int j = 0; j <= MaxTargetDef; j++) row_cells[j] = 8'(j);
    send_idle_pct = 30;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: target bytes at both extremes, exact match, one deletion
    // and substitutions.
    setup_regs(5'd5, 64'h0000_0063_6261_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1);
    add_char(8'h00, 1'b1); add_char(8'hFF, 1'b0); add_char(8'h61, 1'b0);
    add_char(8'h62, 1'b0); add_char(8'h63, 1'b0);
    add_char(8'h00, 1'b1); add_char(8'h61, 1'b0); add_char(8'h62, 1'b0);
    add_char(8'h63, 1'b0);
    add_char(8'hFF, 1'b1); add_char(8'hFF, 1'b0); add_char(8'h63, 1'b0);

    // Directed: a length above the row size is clamped, zero limit.
    setup_regs(5'd31, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    add_char(8'h00, 1'b1); add_char(8'h00, 1'b0); add_char(8'hFF, 1'b0);

    // Directed: empty target, widest limit.
    setup_regs(5'd0, 64'h0102_0304_0506_0708, 64'd0, 8'hFF);
    add_char(8'hAA, 1'b1); add_char(8'h55, 1'b0);

    // Directed: length grows mid-word, so stale cells come back into play.
    wait_drained();
    write_reg(REG_TARGET_LEN, 64'd3);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    add_char(8'h02, 1'b0); add_char(8'h07, 1'b0);

    // Random phases over many register settings and idling patterns.
    for (int p = 0; p < NumPhases; p++) begin
      case (p % 6)
        0:       len = 5'd0;
        1:       len = 5'd16;
        2:       len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(1, 16));
      endcase
      if (p == 3) begin
        lo = 64'd0;
        hi = 64'd0;
      end else if (p == 7) begin
        lo = '1;
        hi = '1;
      end else if ($urandom_range(1) != 0) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end else begin
        for (int b = 0; b < 8; b++) begin
          lo[8*b +: 8] = 8'h61 + 8'($urandom_range(3));
          hi[8*b +: 8] = 8'h61 + 8'($urandom_range(3));
        end
      end
      case (p % 4)
        0:       maxd = 8'd0;
        1:       maxd = 8'hFF;
        2:       maxd = 8'($urandom_range(1, 4));
        default: maxd = 8'($urandom_range(255));
      endcase
      // Long run with one restart only: every cell climbs into saturation.
      if (p == 8) begin
        len  = 5'($urandom_range(0, 3));
        maxd = 8'hFF;
      end

      wait_drained();
      send_idle_pct = (p < 4) ? 30 : (p < 8) ? 77 : 0;
      recv_idle_pct = (p < 4) ? 77 : (p < 8) ? 30 : 0;
      setup_regs(len, lo, hi, maxd);

      if (p == 8) begin
        add_char(8'($urandom), 1'b1);
        for (int i = 1; i < SatChars; i++) add_char(8'($urandom), 1'b0);
        continue;
      end

      // A few characters carry the old row over into the new setting.
      for (int i = 0; i < 3; i++) add_char(8'($urandom), 1'b0);
      queued = 3;
      while (queued < PhaseChars) begin
        if ($urandom_range(99) < 85) begin
          queued -= char_q.size();
          push_word();
          queued += char_q.size();
        end else begin
          add_char(8'($urandom), $urandom_range(9) == 0);
          queued++;
        end
      end

      if (p == 10) begin
        hold_req = 1'b1;
        wait (hold_left != 0);
        hold_req = 1'b0;
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (score_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", score_q.size()));

    $display("%0d characters sent, %0d results checked over %0d register settings",
             chars_sent, results_seen, settings_cnt);
    $display("%0d results within the limit, %0d saturated distances, %0d mismatches",
             hit_seen, sat_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
